// ----- rtl/core/esest_pkg.sv -----
// Package for the encoder speed estimator: request and result types,
// register indexes, reset values, operation codes and the saturation helper.
// No dependencies.
`timescale 1ns / 1ps

package esest_pkg;

	localparam int NUM_CHANNELS_DEF = 2;
	localparam int COUNTER_BITS_DEF = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int ALPHA_W = 17;
	localparam int RPM_W   = 24;
	localparam int DZ_W    = 16;
	localparam int MASK_W  = 2;

	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 24;
	localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;
	localparam int ACC_W   = 50;

	localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LEFT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_RIGHT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RPM_PER_COUNT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE      = 3'd4;

	localparam logic [MASK_W-1:0]  INVERT_MASK_RST   = 2'd1;
	localparam logic [ALPHA_W-1:0] ALPHA_RST         = 17'd19661;
	localparam logic [RPM_W-1:0]   RPM_PER_COUNT_RST = 24'd384000;
	localparam logic [DZ_W-1:0]    DEADZONE_RST      = 16'd512;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

	localparam logic OP_PRIME  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef struct packed {
		logic        operation;
		logic        channel;
		logic [15:0] reading;
	} sample_t;

	typedef struct packed {
		logic               out_channel;
		logic signed [15:0] delta;
		logic signed [31:0] raw_speed;
		logic signed [31:0] speed;
		logic signed [31:0] total_count;
	} result_t;

	function automatic logic signed [31:0] sat_to_32(input logic signed [PROD_W-1:0] v);
		logic sgn;
		logic all_same;
		sgn = v[PROD_W-1];
		all_same = (v[PROD_W-1:31] == {(PROD_W - 31){sgn}});
		if (all_same)
			return v[31:0];
		else if (sgn)
			return 32'sh8000_0000;
		else
			return 32'sh7FFF_FFFF;
	endfunction

endpackage

// ----- rtl/core/encoder_speed_estimator.sv -----
// Encoder speed estimator top level: config registers, per-channel state,
// step sequencer around one shared multiplier. Depends on esest_pkg, esest_mul.
`timescale 1ns / 1ps

// Channel    Handshake                     Payload
// sample     sample_valid / sample_ready   sample (esest_pkg::sample_t)
// result     result_valid / result_ready   result (esest_pkg::result_t)
// config     cfg_we, no back-pressure      cfg_index, cfg_data
//
// A sample update runs the three products (delta*scale, old speed*(1-alpha),
// raw*alpha) one a cycle through the shared multiplier. A prime or an absent
// channel goes from the delta step straight to the last step.
// Reset clears the config registers to defaults and all channel state to zero.
// One request in flight; a new one is taken while the result register still
// waits; the last step holds while result_valid is high and result_ready low.

module encoder_speed_estimator #(
	parameter int NUM_CHANNELS = esest_pkg::NUM_CHANNELS_DEF,
	parameter int COUNTER_BITS = esest_pkg::COUNTER_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [esest_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [esest_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  esest_pkg::sample_t                  sample,
	output logic                                result_valid,
	input  logic                                result_ready,
	output esest_pkg::result_t                  result
);
	import esest_pkg::*;

	localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DELTA = 3'd1;
	localparam logic [2:0] ST_MRAW  = 3'd2;
	localparam logic [2:0] ST_MINV  = 3'd3;
	localparam logic [2:0] ST_MALP  = 3'd4;
	localparam logic [2:0] ST_MIX   = 3'd5;
	localparam logic [2:0] ST_DZ    = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	logic [2:0]           state_q;
	sample_t              req_q;
	result_t              res_q;
	result_t              result_q;
	logic                 result_valid_q;

	logic [MASK_W-1:0]    invert_mask_q;
	logic [ALPHA_W-1:0]   alpha_left_q;
	logic [ALPHA_W-1:0]   alpha_right_q;
	logic [RPM_W-1:0]     rpm_per_count_q;
	logic [DZ_W-1:0]      deadzone_q;

	logic [COUNTER_BITS-1:0] last_reading_q   [NUM_CHANNELS];
	logic signed [31:0]      filtered_speed_q [NUM_CHANNELS];
	logic signed [31:0]      pulse_total_q    [NUM_CHANNELS];

	logic signed [31:0]      delta_q;
	logic signed [31:0]      raw_q;
	logic signed [31:0]      spd_q;
	logic signed [ACC_W-1:0] acc_q;

	logic [CH_IDX_W-1:0]     ch_idx;
	logic                    ch_ok;
	logic [COUNTER_BITS-1:0] rd;
	logic [COUNTER_BITS-1:0] diff;
	logic [COUNTER_BITS-1:0] diff_dir;
	logic signed [31:0]      delta_ext;
	logic [ALPHA_W-1:0]      alpha_sel;
	logic [ALPHA_W-1:0]      alpha_c;
	logic [ALPHA_W-1:0]      inv_alpha;
	logic signed [ACC_W-1:0] mix;
	logic [31:0]             mag;
	logic signed [31:0]      spd_fin;
	logic                    out_free;

	logic                        mul_en;
	logic signed [MUL_A_W-1:0]   mul_a;
	logic        [MUL_B_W-1:0]   mul_b;
	logic signed [PROD_W-1:0]    prod_q;

	esest_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	assign ch_idx    = CH_IDX_W'(req_q.channel);
	assign ch_ok     = (32'(req_q.channel) < NUM_CHANNELS);
	assign rd        = COUNTER_BITS'(req_q.reading);
	assign diff      = rd - last_reading_q[ch_idx];
	assign diff_dir  = invert_mask_q[req_q.channel] ? (~diff + 1'b1) : diff;
	assign delta_ext = 32'($signed(diff_dir));

	assign alpha_sel = req_q.channel ? alpha_right_q : alpha_left_q;
	assign alpha_c   = alpha_sel[ALPHA_W-1] ? ALPHA_ONE : alpha_sel;
	assign inv_alpha = ALPHA_ONE - alpha_c;

	assign mix     = acc_q + ACC_W'(prod_q);
	assign mag     = spd_q[31] ? (~spd_q + 32'd1) : spd_q;
	assign spd_fin = (mag < {16'd0, deadzone_q}) ? 32'sd0 : spd_q;

	assign out_free     = !result_valid_q || result_ready;
	assign sample_ready = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			ST_MRAW: begin
				mul_en = 1'b1;
				mul_a  = delta_q;
				mul_b  = rpm_per_count_q;
			end
			ST_MINV: begin
				mul_en = 1'b1;
				mul_a  = filtered_speed_q[ch_idx];
				mul_b  = MUL_B_W'(inv_alpha);
			end
			ST_MALP: begin
				mul_en = 1'b1;
				mul_a  = raw_q;
				mul_b  = MUL_B_W'(alpha_c);
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_mask_q   <= INVERT_MASK_RST;
			alpha_left_q    <= ALPHA_RST;
			alpha_right_q   <= ALPHA_RST;
			rpm_per_count_q <= RPM_PER_COUNT_RST;
			deadzone_q      <= DEADZONE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INVERT_MASK:   invert_mask_q   <= cfg_data[MASK_W-1:0];
				REG_ALPHA_LEFT:    alpha_left_q    <= cfg_data[ALPHA_W-1:0];
				REG_ALPHA_RIGHT:   alpha_right_q   <= cfg_data[ALPHA_W-1:0];
				REG_RPM_PER_COUNT: rpm_per_count_q <= cfg_data[RPM_W-1:0];
				REG_DEADZONE:      deadzone_q      <= cfg_data[DZ_W-1:0];
				default: ;
			endcase
		end
	end

	// result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (state_q == ST_FIN && out_free)
			result_valid_q <= 1'b1;
		else if (result_ready)
			result_valid_q <= 1'b0;
	end

	// sequencer and channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				last_reading_q[i]   <= '0;
				filtered_speed_q[i] <= '0;
				pulse_total_q[i]    <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (sample_valid)
						state_q <= ST_DELTA;
				end
				ST_DELTA: begin
					if (!ch_ok || req_q.operation == OP_PRIME) begin
						if (ch_ok) begin
							last_reading_q[ch_idx]   <= rd;
							filtered_speed_q[ch_idx] <= '0;
							pulse_total_q[ch_idx]    <= '0;
						end
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_MRAW;
					end
				end
				ST_MRAW: state_q <= ST_MINV;
				ST_MINV: state_q <= ST_MALP;
				ST_MALP: state_q <= ST_MIX;
				ST_MIX:  state_q <= ST_DZ;
				ST_DZ: begin
					last_reading_q[ch_idx]   <= rd;
					filtered_speed_q[ch_idx] <= spd_fin;
					pulse_total_q[ch_idx]    <= pulse_total_q[ch_idx] + delta_q;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid)
					req_q <= sample;
			end
			ST_DELTA: begin
				delta_q           <= delta_ext;
				res_q.out_channel <= req_q.channel;
				res_q.delta       <= '0;
				res_q.raw_speed   <= '0;
				res_q.speed       <= '0;
				res_q.total_count <= '0;
			end
			ST_MINV: raw_q <= sat_to_32(prod_q >>> 8);
			ST_MALP: acc_q <= ACC_W'(prod_q);
			ST_MIX:  spd_q <= sat_to_32(PROD_W'(mix >>> 16));
			ST_DZ: begin
				res_q.delta       <= 16'(delta_q);
				res_q.raw_speed   <= raw_q;
				res_q.speed       <= spd_fin;
				res_q.total_count <= pulse_total_q[ch_idx] + delta_q;
			end
			ST_FIN: begin
				if (out_free)
					result_q <= res_q;
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/core/esest_mul.sv -----
// Shared signed-by-unsigned multiplier with registered product.
// Depends on esest_pkg.
`timescale 1ns / 1ps

module esest_mul (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [esest_pkg::MUL_A_W-1:0]  a,
	input  logic        [esest_pkg::MUL_B_W-1:0]  b,
	output logic signed [esest_pkg::PROD_W-1:0]   prod_q
);
	import esest_pkg::*;

	logic signed [MUL_B_W:0]   b_s;
	logic signed [PROD_W-1:0]  prod;

	assign b_s  = $signed({1'b0, b});
	assign prod = PROD_W'(a) * PROD_W'(b_s);

	always_ff @(posedge clk) begin
		if (en)
			prod_q <= prod;
	end

endmodule

// ----- sim/esest_checker.sv -----
// Checker for the encoder speed estimator: follows register writes, predicts each
// result from the accepted requests and compares it field by field with the block.
// Depends on esest_pkg.
`timescale 1ns / 1ps

module esest_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [esest_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [esest_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             sample_valid,
	input  logic                             sample_ready,
	input  esest_pkg::sample_t               sample,
	input  logic                             result_valid,
	input  logic                             result_ready,
	input  esest_pkg::result_t               result,
	output int                               fail_count,
	output int                               pending,
	output int                               checked
);
	import esest_pkg::*;

	localparam longint SPEED_MAX = 64'sd2147483647;
	localparam longint SPEED_MIN = -64'sd2147483648;
	localparam longint UNITY     = 64'sd65536;

	logic [MASK_W-1:0]  invert_bits;
	logic [ALPHA_W-1:0] alpha_reg [2];
	logic [RPM_W-1:0]   scale_reg;
	logic [DZ_W-1:0]    deadzone_reg;

	logic [15:0]        last_reading [2];
	logic signed [31:0] filt_speed [2];
	logic [31:0]        pulse_sum [2];

	result_t due_results [$];
	result_t next_due;

	function automatic logic signed [31:0] clip32(input longint v);
		if (v > SPEED_MAX)
			return 32'sh7FFF_FFFF;
		if (v < SPEED_MIN)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// Advances one channel's state and gives the result the request should produce.
	task automatic step_channel(input sample_t req, output result_t res);
		logic               ch;
		logic [15:0]        diff;
		logic signed [31:0] raw;
		logic signed [31:0] spd;
		longint             wt;
		longint             mix;
		longint             mag;
		ch = req.channel;
		res = '0;
		res.out_channel = ch;
		if (req.operation == OP_PRIME) begin
			last_reading[ch] = req.reading;
			filt_speed[ch] = '0;
			pulse_sum[ch] = '0;
			return;
		end
		diff = req.reading - last_reading[ch];
		if (invert_bits[ch])
			diff = 16'd0 - diff;
		last_reading[ch] = req.reading;
		raw = clip32((longint'(signed'(diff)) * longint'(scale_reg)) >>> 8);
		wt = longint'(alpha_reg[ch]);
		if (wt > UNITY)
			wt = UNITY;
		mix = longint'(filt_speed[ch]) * (UNITY - wt) + longint'(raw) * wt;
		spd = clip32(mix >>> 16);
		mag = (spd < 0) ? -longint'(spd) : longint'(spd);
		if (mag < longint'(deadzone_reg))
			spd = '0;
		filt_speed[ch] = spd;
		pulse_sum[ch] = pulse_sum[ch] + {{16{diff[15]}}, diff};
		res.delta = diff;
		res.raw_speed = raw;
		res.speed = spd;
		res.total_count = pulse_sum[ch];
	endtask

	task automatic flag_mismatch(input string what);
		if (fail_count < 40)
			$display("%0t: mismatch: %s", $time, what);
		fail_count++;
	endtask

	task automatic check_result(input result_t got, input result_t want);
		if (got.out_channel !== want.out_channel)
			flag_mismatch($sformatf("result %0d channel got %0d want %0d",
				checked, got.out_channel, want.out_channel));
		if (got.delta !== want.delta)
			flag_mismatch($sformatf("result %0d delta got %0d want %0d",
				checked, got.delta, want.delta));
		if (got.raw_speed !== want.raw_speed)
			flag_mismatch($sformatf("result %0d raw_speed got %0d want %0d",
				checked, got.raw_speed, want.raw_speed));
		if (got.speed !== want.speed)
			flag_mismatch($sformatf("result %0d speed got %0d want %0d",
				checked, got.speed, want.speed));
		if (got.total_count !== want.total_count)
			flag_mismatch($sformatf("result %0d total_count got %0d want %0d",
				checked, got.total_count, want.total_count));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_bits = INVERT_MASK_RST;
			alpha_reg[0] = ALPHA_RST;
			alpha_reg[1] = ALPHA_RST;
			scale_reg = RPM_PER_COUNT_RST;
			deadzone_reg = DEADZONE_RST;
			for (int c = 0; c < 2; c++) begin
				last_reading[c] = '0;
				filt_speed[c] = '0;
				pulse_sum[c] = '0;
			end
			due_results.delete();
			fail_count = 0;
			pending = 0;
			checked = 0;
		end else begin
			// results are retired before the same edge's request is queued
			if (result_valid && result_ready) begin
				if (due_results.size() == 0)
					flag_mismatch("result with no request outstanding");
				else
					check_result(result, due_results.pop_front());
				checked++;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_INVERT_MASK:   invert_bits = cfg_data[MASK_W-1:0];
					REG_ALPHA_LEFT:    alpha_reg[0] = cfg_data[ALPHA_W-1:0];
					REG_ALPHA_RIGHT:   alpha_reg[1] = cfg_data[ALPHA_W-1:0];
					REG_RPM_PER_COUNT: scale_reg = cfg_data[RPM_W-1:0];
					REG_DEADZONE:      deadzone_reg = cfg_data[DZ_W-1:0];
					default: ;
				endcase
			end
			if (sample_valid && sample_ready) begin
				step_channel(sample, next_due);
				due_results.push_back(next_due);
			end
			pending = due_results.size();
		end
	end

endmodule

// ----- sim/tb_encoder_speed_estimator.sv -----
// Testbench top for the encoder speed estimator: clock, reset, request and register
// stimulus, random back-pressure and the verdict. Depends on esest_pkg,
// encoder_speed_estimator and esest_checker.
`timescale 1ns / 1ps

module tb_encoder_speed_estimator;
	import esest_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASES      = 8;
	localparam int PHASE_REQS  = 212;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  sample_valid = 1'b0;
	logic                  sample_ready;
	sample_t               sample = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_t               result;

	int          fail_count;
	int          pending;
	int          checked;
	int          cycles = 0;
	int          primes_sent = 0;
	int          updates_sent = 0;
	bit          calm = 1'b0;
	logic [15:0] last_sent [2] = '{16'd0, 16'd0};

	encoder_speed_estimator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	esest_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.fail_count   (fail_count),
		.pending      (pending),
		.checked      (checked)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(negedge clk)
		result_ready <= calm || ($urandom_range(0, 99) >= 36);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_encoder_speed_estimator NOT OK");
			$finish;
		end
	end

	task automatic send_req(input logic op, input logic ch, input logic [15:0] rd);
		while (!calm && $urandom_range(0, 99) < 36) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample <= '{operation: op, channel: ch, reading: rd};
		sample_valid <= 1'b1;
		do
			@(posedge clk);
		while (!sample_ready);
		@(negedge clk);
		last_sent[ch] = rd;
		if (op == OP_PRIME)
			primes_sent++;
		else
			updates_sent++;
	endtask

	// Stop sending and let every outstanding request come back.
	task automatic drain();
		sample_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_alpha();
		int k;
		k = $urandom_range(0, 99);
		if (k < 10)
			return '0;
		if (k < 20)
			return CFG_DATA_W'($urandom_range(65537, 131071));
		if (k < 30)
			return CFG_DATA_W'(ALPHA_ONE);
		return CFG_DATA_W'($urandom_range(1, 65535));
	endfunction

	task automatic apply_setting(input int p);
		logic [CFG_DATA_W-1:0] inv;
		logic [CFG_DATA_W-1:0] al;
		logic [CFG_DATA_W-1:0] ar;
		logic [CFG_DATA_W-1:0] scale;
		logic [CFG_DATA_W-1:0] dz;
		int                    k;
		case (p)
			0: begin
				inv = 0;
				al = CFG_DATA_W'(ALPHA_ONE);
				ar = 0;
				scale = 24'hFF_FFFF;
				dz = 0;
			end
			1: begin
				inv = 3;
				al = 131071;
				ar = 1;
				scale = 0;
				dz = 65535;
			end
			2: begin
				inv = 2;
				al = 65537;
				ar = CFG_DATA_W'(ALPHA_ONE);
				scale = 1;
				dz = 0;
			end
			PHASES - 1: begin
				inv = CFG_DATA_W'(INVERT_MASK_RST);
				al = CFG_DATA_W'(ALPHA_RST);
				ar = CFG_DATA_W'(ALPHA_RST);
				scale = RPM_PER_COUNT_RST;
				dz = CFG_DATA_W'(DEADZONE_RST);
			end
			default: begin
				inv = CFG_DATA_W'($urandom_range(0, 3));
				al = pick_alpha();
				ar = pick_alpha();
				k = $urandom_range(0, 99);
				if (k < 20)
					scale = CFG_DATA_W'($urandom_range(0, 24'hFF_FFFF));
				else
					scale = CFG_DATA_W'($urandom_range(1000, 1000000));
				k = $urandom_range(0, 99);
				if (k < 15)
					dz = 0;
				else if (k < 25)
					dz = CFG_DATA_W'($urandom_range(0, 65535));
				else
					dz = CFG_DATA_W'($urandom_range(1, 4000));
			end
		endcase
		write_reg(REG_INVERT_MASK, inv);
		write_reg(REG_ALPHA_LEFT, al);
		write_reg(REG_ALPHA_RIGHT, ar);
		write_reg(REG_RPM_PER_COUNT, scale);
		write_reg(REG_DEADZONE, dz);
	endtask

	// Mostly plausible wheel motion, with jumps, half-range steps and full noise.
	task automatic random_req();
		logic        ch;
		logic        op;
		logic [15:0] rd;
		int          k;
		int          step;
		ch = 1'($urandom_range(0, 1));
		op = ($urandom_range(0, 99) < 8) ? OP_PRIME : OP_SAMPLE;
		k = $urandom_range(0, 99);
		if (k < 45)
			step = int'($urandom_range(0, 128)) - 64;
		else if (k < 70)
			step = int'($urandom_range(0, 4000)) - 2000;
		else if (k < 94)
			step = 0;
		else
			step = 1;
		rd = last_sent[ch] + step[15:0];
		if (k >= 70 && k < 88) begin
			rd = 16'($urandom_range(0, 65535));
		end else if (k >= 88 && k < 94) begin
			case ($urandom_range(0, 2))
				0: step = 32768;
				1: step = 32767;
				default: step = -32767;
			endcase
			rd = last_sent[ch] + step[15:0];
		end else if (k >= 94) begin
			rd = last_sent[ch];
		end
		send_req(op, ch, rd);
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// reset register values: left inverted, right not
		send_req(OP_PRIME,  1'b0, 16'd0);
		send_req(OP_PRIME,  1'b1, 16'd65535);
		send_req(OP_SAMPLE, 1'b0, 16'd32768);
		send_req(OP_SAMPLE, 1'b1, 16'd32767);
		send_req(OP_SAMPLE, 1'b0, 16'd32767);
		send_req(OP_SAMPLE, 1'b0, 16'd32767);
		send_req(OP_SAMPLE, 1'b1, 16'd32767);
		send_req(OP_SAMPLE, 1'b1, 16'd32867);
		send_req(OP_SAMPLE, 1'b1, 16'd32967);
		send_req(OP_SAMPLE, 1'b1, 16'd33067);
		send_req(OP_SAMPLE, 1'b0, 16'd0);
		send_req(OP_SAMPLE, 1'b0, 16'd65535);
		send_req(OP_SAMPLE, 1'b0, 16'd1);
		send_req(OP_SAMPLE, 1'b1, 16'd0);
		send_req(OP_SAMPLE, 1'b1, 16'd65535);
		send_req(OP_PRIME,  1'b1, 16'd12345);
		send_req(OP_SAMPLE, 1'b1, 16'd12346);
		send_req(OP_SAMPLE, 1'b0, 16'hAAAA);
		send_req(OP_SAMPLE, 1'b0, 16'h5555);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			apply_setting(p);
			calm <= (p == 3);
			for (int i = 0; i < PHASE_REQS; i++)
				random_req();
			calm <= 1'b0;
		end
		drain();

		$display("Sent %0d speed updates and %0d primes under %0d register settings.",
			updates_sent, primes_sent, PHASES + 1);
		$display("Compared %0d results field by field; %0d field errors.", checked, fail_count);
		if (fail_count == 0)
			$display("tb_encoder_speed_estimator OK");
		else
			$display("tb_encoder_speed_estimator NOT OK");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/esest_pkg.sv
rtl/core/esest_mul.sv
rtl/core/encoder_speed_estimator.sv
sim/esest_checker.sv
sim/tb_encoder_speed_estimator.sv
